@@ src/assert_macros.svh @@
// Assertion helpers for the base64 encoder.
// Both macros sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define B64E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/b64e_pkg.sv @@
package b64e_pkg;

  // Default number of encoded groups that can wait between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Byte counts of a group.
  localparam logic [1:0] GROUP_ONE  = 2'd1;
  localparam logic [1:0] GROUP_TWO  = 2'd2;
  localparam logic [1:0] GROUP_FULL = 2'd3;

  // Index of the fourth character of a group.
  localparam logic [1:0] CHAR_LAST_IDX = 2'd3;

  // ASCII codes used outside the letter and digit ranges.
  localparam logic [6:0] CHAR_PAD   = 7'd61;  // '='
  localparam logic [6:0] CHAR_PLUS  = 7'd43;  // '+'
  localparam logic [6:0] CHAR_SLASH = 7'd47;  // '/'
  localparam logic [6:0] CHAR_UPPER = 7'd65;  // 'A'
  localparam logic [6:0] CHAR_LOWER = 7'd71;  // 'a' minus 26
  localparam logic [6:0] CHAR_DIGIT = 7'd4;   // 52 minus '0'

  // One group handed from front to back: bytes left-aligned and zero-filled.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  total;
    logic        last;
  } b64e_group_t;

  // Queue status seen by the front, the back and the checks.
  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  // Maps a six-bit value to its character in the standard alphabet.
  function automatic logic [6:0] b64e_char(input logic [5:0] sextet);
    logic [6:0] code;
    code = {1'b0, sextet};
    if (sextet < 6'd26) begin
      return code + CHAR_UPPER;
    end else if (sextet < 6'd52) begin
      return code + CHAR_LOWER;
    end else if (sextet < 6'd62) begin
      return code - CHAR_DIGIT;
    end else if (sextet == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

@@ src/base64_stream_encoder.sv @@
// Streaming base64 encoder with the standard alphabet and '=' padding.
// Input channel: in_valid/in_ready carry one message byte (data_byte) and
// is_final, which marks the last byte of a message. Output channel:
// out_valid/out_ready carry one ASCII character (out_char); out_last is set
// on the final character of the message.
// Every third byte, or a byte with is_final set, closes a group. The group
// goes into a queue of QUEUE_DEPTH entries and is spelled out as four
// characters, one per cycle while the receiver accepts them; a short group
// ends in one or two '='. A group passes through the queue slot, the back's
// group register and the output register before its first character is
// valid. The single output character port sets the throughput: four
// characters per group of three bytes. Bytes are taken one per cycle while
// the queue has room.
// Reset clears the open group, the queue and the output register; the next
// byte starts a new message. If the receiver stalls, the current character
// is held, the queue fills, and in_ready drops once it is full.
`include "assert_macros.svh"

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last
);

  b64e_qstat_t q_stat;
  b64e_group_t grp_in;
  b64e_group_t grp_head;
  logic        push;
  logic        pop;

  // Front: gathers bytes into groups.
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_byte(data_byte),
    .is_final (is_final),
    .q_stat   (q_stat),
    .push     (push),
    .grp      (grp_in)
  );

  // Queue of finished groups.
  b64e_queue #(
    .DEPTH(QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_grp(grp_in),
    .pop     (pop),
    .head    (grp_head),
    .q_stat  (q_stat)
  );

  // Back: four characters per group.
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (grp_head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .out_last (out_last)
  );

  // Queue is never written when full nor read when empty.
  `B64E_ASSERT(a_no_overflow, push |-> !q_stat.full, "group pushed into a full queue")
  `B64E_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "group popped from an empty queue")
  // A group holds at least one byte, and a short group only closes a message.
  `B64E_ASSERT(a_group_nonempty, push |-> grp_in.total != 2'd0, "empty group pushed")
  `B64E_ASSERT(a_short_is_last, push && grp_in.total != GROUP_FULL |-> grp_in.last,
               "short group without final mark")
  // Nothing leaves the block in the cycle after a reset edge.
  `B64E_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output valid after reset")

endmodule

@@ src/b64e_front.sv @@
module b64e_front
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_final,
  input  b64e_qstat_t q_stat,
  output logic        push,
  output b64e_group_t grp
);

  logic [15:0] pending;
  logic [1:0]  count;
  logic [1:0]  held;
  logic [1:0]  total;
  logic        complete;
  logic        accept;

  // A request is taken whenever the queue has room for a finished group.
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Classify the byte: does it close the current group?
  always_comb begin
    held     = (count == GROUP_FULL) ? GROUP_TWO : count;
    total    = held + 2'd1;
    complete = (total == GROUP_FULL) || is_final;
    push     = accept && complete;
    grp.total = total;
    grp.last  = is_final;
    case (total)
      GROUP_ONE: grp.word = {data_byte, 16'h0000};
      GROUP_TWO: grp.word = {pending[7:0], data_byte, 8'h00};
      default:   grp.word = {pending, data_byte};
    endcase
  end

  // Hold the bytes of an open group.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= complete ? 2'd0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= complete ? 16'h0000 : {pending[7:0], data_byte};
    end
  end

endmodule

@@ src/b64e_queue.sv @@
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64e_group_t push_grp,
  input  logic        pop,
  output b64e_group_t head,
  output b64e_qstat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_group_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_stat.full  = (fill == CNT_W'(DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = slots[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Group storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_grp;
    end
  end

endmodule

@@ src/b64e_back.sv @@
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  b64e_group_t head,
  input  b64e_qstat_t q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char,
  output logic        out_last
);

  logic        busy;
  b64e_group_t cur;
  logic [1:0]  idx;
  logic        emit;
  logic        done;
  logic [5:0]  sextet;
  logic [6:0]  char_next;

  // A character moves into the output register when that register is free.
  always_comb begin
    emit = busy && (!out_valid || out_ready);
    done = emit && (idx == CHAR_LAST_IDX);
    pop  = !q_stat.empty && (!busy || done);
    case (idx)
      2'd0:    sextet = cur.word[23:18];
      2'd1:    sextet = cur.word[17:12];
      2'd2:    sextet = cur.word[11:6];
      default: sextet = cur.word[5:0];
    endcase
    char_next = (idx > cur.total) ? CHAR_PAD : b64e_char(sextet);
  end

  // Group being spelled out and its character counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else begin
      if (done) begin
        busy <= 1'b0;
      end
      if (emit) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      out_last <= cur.last && (idx == CHAR_LAST_IDX);
    end
  end

endmodule
